// File: hw/rtl/tbbd_pkg.sv
// Package with the payload types and the constants of the Bernstein basis unit.
`default_nettype none
package tbbd_pkg;

  localparam int unsigned OneQ16 = 65536;

  typedef enum logic [0:0] {
    REG_DEGREE      = 1'b0,
    REG_DERIV_ORDER = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [16:0] xi_first;
    logic [16:0] xi_second;
  } in_item_t;

  typedef struct packed {
    logic        [3:0]  basis_index;
    logic        [16:0] basis_value;
    logic signed [31:0] deriv_first;
    logic signed [31:0] deriv_second;
    logic signed [31:0] deriv_second_second;
    logic signed [31:0] deriv_mixed;
    logic signed [31:0] deriv_first_first;
    logic               last;
  } out_item_t;

endpackage
`default_nettype wire

// File: hw/rtl/tbbd_univariate.sv
// Pipelined univariate Bernstein values and derivatives, one recurrence level per stage.
`default_nettype none
module tbbd_univariate #(
  parameter int unsigned MaxDeg = 3
) (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [16:0]                   x_i,
  input  wire logic [$clog2(MaxDeg+1)-1:0]   deg_i,
  output logic [MaxDeg:0][28:0]              val_o,
  output logic signed [MaxDeg:0][33:0]       d1_o,
  output logic signed [MaxDeg:0][35:0]       d2_o
);

  localparam int unsigned DW = $clog2(MaxDeg + 1);

  // Row q of the triangle lives in stage q; rows of lower degree are carried along.
  logic [MaxDeg:0][MaxDeg:0][28:0] rows_q [MaxDeg+1];
  logic [16:0]                     x_q    [MaxDeg+1];
  logic [DW-1:0]                   deg_q  [MaxDeg+1];

  always_ff @(posedge clk_i) begin
    logic [MaxDeg:0][MaxDeg:0][28:0] init;
    init = '0;
    init[0][0] = 29'(1 << 28);
    if (en_i) begin
      x_q[0]   <= (x_i > 17'(tbbd_pkg::OneQ16)) ? 17'(tbbd_pkg::OneQ16) : x_i;
      deg_q[0] <= deg_i;
      rows_q[0] <= init;
    end
  end

  for (genvar q = 1; q <= MaxDeg; q++) begin : g_lvl
    logic [MaxDeg:0][28:0]           row_d;
    logic [MaxDeg:0][MaxDeg:0][28:0] stage_d;
    always_comb begin
      logic [45:0] acc;
      logic [16:0] u;
      u = 17'(tbbd_pkg::OneQ16) - x_q[q-1];
      row_d = '0;
      for (int k = 0; k <= q; k++) begin
        acc = 46'(1 << 15);
        if (k < q) acc = acc + 46'(u) * 46'(rows_q[q-1][q-1][k]);
        if (k > 0) acc = acc + 46'(x_q[q-1]) * 46'(rows_q[q-1][q-1][k-1]);
        row_d[k] = acc[44:16];
      end
      stage_d = rows_q[q-1];
      stage_d[q] = row_d;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rows_q[q]    <= stage_d;
        x_q[q]       <= x_q[q-1];
        deg_q[q]     <= deg_q[q-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k <= MaxDeg; k++) begin
        logic signed [35:0] a1, a0, b2, b1, b0;
        int p;
        p  = int'(deg_q[MaxDeg]);
        a1 = (k >= 1 && k - 1 <= p - 1) ? 36'(rows_q[MaxDeg][p-1][k-1]) : '0;
        a0 = (k <= p - 1) ? 36'(rows_q[MaxDeg][p-1][k]) : '0;
        b2 = (p >= 2 && k >= 2 && k - 2 <= p - 2) ? 36'(rows_q[MaxDeg][p-2][k-2]) : '0;
        b1 = (p >= 2 && k >= 1 && k - 1 <= p - 2) ? 36'(rows_q[MaxDeg][p-2][k-1]) : '0;
        b0 = (p >= 2 && k <= p - 2) ? 36'(rows_q[MaxDeg][p-2][k]) : '0;
        val_o[k] <= (k <= p) ? rows_q[MaxDeg][p][k] : '0;
        d1_o[k]  <= 34'((a1 - a0) * 36'(p));
        d2_o[k]  <= (p >= 2) ? 36'((b2 - (b1 <<< 1) + b0) * 36'(p * (p - 1))) : '0;
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/tbbd_product.sv
// Registered product of two Q.28 terms, rounded and saturated to the output format.
`default_nettype none
module tbbd_product #(
  parameter bit IsValue = 1'b0
) (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [35:0] a_i,
  input  wire logic signed [35:0] b_i,
  input  wire logic               zero_i,
  output logic        [31:0]      res_o
);

  logic        [31:0] ma_q, mb_q;
  logic               neg_q, zero_q;
  logic        [63:0] prod_q;
  logic               neg2_q, zero2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q    <= a_i[35] ? 32'(-a_i) : a_i[31:0];
      mb_q    <= b_i[35] ? 32'(-b_i) : b_i[31:0];
      neg_q   <= a_i[35] ^ b_i[35];
      zero_q  <= zero_i;
      prod_q  <= 64'(ma_q) * 64'(mb_q);
      neg2_q  <= neg_q;
      zero2_q <= zero_q;
    end
  end

  logic [32:0] m;
  always_comb begin
    logic [64:0] r;
    r = 65'(prod_q) + (65'd1 << 39);
    m = 33'(r[64:40]);
    if (zero2_q) begin
      res_o = '0;
    end else if (IsValue) begin
      res_o = neg2_q ? '0 : ((m > 33'(tbbd_pkg::OneQ16)) ? 32'(tbbd_pkg::OneQ16) : m[31:0]);
    end else if (neg2_q) begin
      res_o = (m > 33'h80000000) ? 32'h80000000 : 32'(-m);
    end else begin
      res_o = (m > 33'h7FFFFFFF) ? 32'h7FFFFFFF : m[31:0];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/tensor_bernstein_basis_derivs_unit.sv
// Top level of the tensor-product Bernstein basis unit with derivatives.
// One transfer in gives (degree+1)^2 results (16 at degree 3), row-major, one per cycle
// while the output is not stalled; degree 0 runs as degree 1 and larger degrees are clamped
// to MAX_DEGREE. Points run through MAX_DEGREE+2 recurrence stages, wait at the end of that
// pipeline until the walker is free, then go through the walker register, a row of two-stage
// multipliers and an output register. Points may be taken every cycle until the recurrence
// pipeline fills, and a stalled output holds the whole unit.
`default_nettype none
module tensor_bernstein_basis_derivs_unit #(
  parameter int unsigned MAX_DEGREE = 3
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire tbbd_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output tbbd_pkg::out_item_t      out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [0:0]          cfg_index_i,
  input  wire logic [1:0]          cfg_data_i
);

  localparam int unsigned DW = $clog2(MAX_DEGREE + 1);
  localparam int unsigned IW = 2 * DW;

  logic [1:0] degree_q, order_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= 2'd3;
      order_q  <= 2'd2;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tbbd_pkg::REG_DEGREE:      degree_q <= cfg_data_i;
        tbbd_pkg::REG_DERIV_ORDER: order_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [DW-1:0] p_eff;
  always_comb begin
    if (degree_q == 2'd0) p_eff = DW'(1);
    else if (32'(degree_q) > MAX_DEGREE) p_eff = DW'(MAX_DEGREE);
    else p_eff = DW'(degree_q);
  end

  // The walker and product stages advance whenever the output register can move.
  logic en;
  assign en = !out_valid_o || out_ready_i;

  logic [MAX_DEGREE:0][28:0]        nv, mv;
  logic signed [MAX_DEGREE:0][33:0] n1, m1;
  logic signed [MAX_DEGREE:0][35:0] n2, m2;

  localparam int unsigned UL = MAX_DEGREE + 2;
  logic          vld_q [UL];
  logic [DW-1:0] p_q   [UL];
  logic          sec_q [UL];
  logic          acc;

  logic [MAX_DEGREE:0][28:0]        hv, gv;
  logic signed [MAX_DEGREE:0][33:0] h1, g1;
  logic signed [MAX_DEGREE:0][35:0] h2, g2;
  logic [MAX_DEGREE:0][28:0]        hv_q, gv_q;
  logic signed [MAX_DEGREE:0][33:0] h1_q, g1_q;
  logic signed [MAX_DEGREE:0][35:0] h2_q, g2_q;
  logic [DW-1:0] hp_q, i_q, j_q;
  logic          hsec_q, busy_q;

  // The walker is busy from the point where coefficients arrive until the last pair.
  logic wlast, load, uen;
  assign wlast = busy_q && (i_q == hp_q) && (j_q == hp_q);
  assign load  = vld_q[UL-1] && (!busy_q || wlast);
  // The recurrence pipeline holds while its finished point waits for the walker.
  assign uen   = en && (!vld_q[UL-1] || load);
  assign in_ready_o = uen;
  assign acc = in_valid_i && in_ready_o;

  tbbd_univariate #(.MaxDeg(MAX_DEGREE)) u_first (
    .clk_i, .en_i(uen), .x_i(in_data_i.xi_first), .deg_i(p_eff),
    .val_o(nv), .d1_o(n1), .d2_o(n2));
  tbbd_univariate #(.MaxDeg(MAX_DEGREE)) u_second (
    .clk_i, .en_i(uen), .x_i(in_data_i.xi_second), .deg_i(p_eff),
    .val_o(mv), .d1_o(m1), .d2_o(m2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < UL; s++) vld_q[s] <= 1'b0;
    end else if (uen) begin
      vld_q[0] <= acc;
      for (int s = 1; s < UL; s++) vld_q[s] <= vld_q[s-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (uen) begin
      p_q[0]   <= p_eff;
      sec_q[0] <= (order_q != 2'd1) && (order_q != 2'd0);
      for (int s = 1; s < UL; s++) begin
        p_q[s]   <= p_q[s-1];
        sec_q[s] <= sec_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (en) begin
      if (load) busy_q <= 1'b1;
      else if (wlast) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (load) begin
        hv_q <= nv; h1_q <= n1; h2_q <= n2;
        gv_q <= mv; g1_q <= m1; g2_q <= m2;
        hp_q <= p_q[UL-1]; hsec_q <= sec_q[UL-1];
        i_q <= '0; j_q <= '0;
      end else if (busy_q) begin
        if (j_q == hp_q) begin
          j_q <= '0;
          i_q <= i_q + DW'(1);
        end else begin
          j_q <= j_q + DW'(1);
        end
      end
    end
  end

  assign hv = hv_q; assign h1 = h1_q; assign h2 = h2_q;
  assign gv = gv_q; assign g1 = g1_q; assign g2 = g2_q;

  logic signed [35:0] av, a1, a2, bv, b1, b2;
  assign av = 36'(hv[i_q]);
  assign a1 = 36'($signed(h1[i_q]));
  assign a2 = h2[i_q];
  assign bv = 36'(gv[j_q]);
  assign b1 = 36'($signed(g1[j_q]));
  assign b2 = g2[j_q];

  // Two product stages carry index, last and valid.
  logic          mv_q [2];
  logic          ml_q [2];
  logic [IW-1:0] mi_q [2];
  logic [IW-1:0] idx;
  assign idx = IW'(i_q) * (IW'(hp_q) + IW'(1)) + IW'(j_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q[0] <= 1'b0;
      mv_q[1] <= 1'b0;
    end else if (en) begin
      mv_q[0] <= busy_q;
      mv_q[1] <= mv_q[0];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      ml_q[0] <= wlast;
      ml_q[1] <= ml_q[0];
      mi_q[0] <= idx;
      mi_q[1] <= mi_q[0];
    end
  end

  logic [31:0] r_v, r_1, r_2, r_22, r_m, r_11;
  logic nz;
  assign nz = !hsec_q;
  tbbd_product #(.IsValue(1'b1)) u_pv (.clk_i, .en_i(en), .a_i(av), .b_i(bv), .zero_i(1'b0), .res_o(r_v));
  tbbd_product u_p1  (.clk_i, .en_i(en), .a_i(a1), .b_i(bv), .zero_i(1'b0), .res_o(r_1));
  tbbd_product u_p2  (.clk_i, .en_i(en), .a_i(av), .b_i(b1), .zero_i(1'b0), .res_o(r_2));
  tbbd_product u_p22 (.clk_i, .en_i(en), .a_i(av), .b_i(b2), .zero_i(nz),   .res_o(r_22));
  tbbd_product u_pm  (.clk_i, .en_i(en), .a_i(a1), .b_i(b1), .zero_i(nz),   .res_o(r_m));
  tbbd_product u_p11 (.clk_i, .en_i(en), .a_i(a2), .b_i(bv), .zero_i(nz),   .res_o(r_11));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= mv_q[1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_o.basis_index         <= 4'(mi_q[1]);
      out_data_o.basis_value         <= r_v[16:0];
      out_data_o.deriv_first         <= r_1;
      out_data_o.deriv_second        <= r_2;
      out_data_o.deriv_second_second <= r_22;
      out_data_o.deriv_mixed         <= r_m;
      out_data_o.deriv_first_first   <= r_11;
      out_data_o.last                <= ml_q[1];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/tbbd_checker.sv
// Port-level checker for the Bernstein basis unit and its bind.
`default_nettype none
module tbbd_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire tbbd_pkg::out_item_t out_data_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped while stalled");
  a_val_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.basis_value <= 17'd65536)
    else $error("basis value out of range");
  a_first_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.last |=> !out_valid_o || out_data_o.basis_index == 4'd0)
    else $error("point does not start at index zero");
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |-> out_data_o.basis_index != 4'd0)
    else $error("last flag on first index");

endmodule

bind tensor_bernstein_basis_derivs_unit tbbd_checker u_tbbd_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .out_data_o);
`default_nettype wire
